// File: hw/rtl/pig_pkg.sv
// ----------------------------------------------------------------------------
// pig_pkg: shared types and constants of the primitive index generator
// Request and primitive codes, result kinds, and the front-to-back command.
// ----------------------------------------------------------------------------
package pig_pkg;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_VERTEX  = 2'd1;
  localparam logic [1:0] REQ_STATUS  = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [2:0] PRIM_QUADS     = 3'd0;
  localparam logic [2:0] PRIM_IGNORED   = 3'd1;
  localparam logic [2:0] PRIM_LIST      = 3'd2;
  localparam logic [2:0] PRIM_STRIP     = 3'd3;
  localparam logic [2:0] PRIM_FAN       = 3'd4;
  localparam logic [2:0] PRIM_LINES     = 3'd5;
  localparam logic [2:0] PRIM_LINESTRIP = 3'd6;
  localparam logic [2:0] PRIM_POINTS    = 3'd7;

  localparam logic [1:0] KIND_TRI    = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_POINT  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [15:0] RESTART_MARK = 16'hFFFF;
  localparam int          MAX_SLOTS    = 6;

  // One slot of a command: an index offset or the restart marker.
  typedef struct packed {
    logic        mark;
    logic [15:0] offset;
  } slot_t;

  // Work item handed from the classifier to the emitter.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  count;      // number of results, 1..6
    slot_t [5:0] slots;
    logic [15:0] base;       // running index, low 16 bits
    logic [31:0] tri_count;
    logic [31:0] line_count;
    logic [31:0] point_count;
    logic [15:0] remaining;
  } cmd_t;

endpackage

// File: hw/rtl/pig_if.sv
// ----------------------------------------------------------------------------
// pig_in_if / pig_out_if / pig_cfg_if: valid-ready channels
// Request, result and configuration channels of the index generator.
// ----------------------------------------------------------------------------
interface pig_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  prim_type;
  logic [15:0] batch_count;
  modport source (output valid, req_type, prim_type, batch_count, input ready);
  modport sink (input valid, req_type, prim_type, batch_count, output ready);
endinterface

interface pig_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] index_value;
  logic        last;
  logic [31:0] tri_count;
  logic [31:0] line_count;
  logic [31:0] point_count;
  logic [15:0] remaining;
  modport source (output valid, kind, index_value, last, tri_count, line_count,
                  point_count, remaining, input ready);
  modport sink (input valid, kind, index_value, last, tri_count, line_count,
                point_count, remaining, output ready);
endinterface

interface pig_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: hw/rtl/primitive_index_generator_unit.sv
// ----------------------------------------------------------------------------
// primitive_index_generator_unit: primitive assembly index generator
// Turns vertex requests into triangle, line and point index streams.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | req_type, prim_type, batch_count
// res     | out | kind, index_value, last, tri/line/point_count, remaining
// cfg     | in  | data = restart_enable
//
// A request is classified into a registered command; its command then emits
// one result per cycle (up to six) while the result port is not stalled;
// the emitter walking slots sets the rate.
// Reset (rst, synchronous) clears counts, batch position and restart_enable.
// A stalled result holds the emitter; the two-entry queue and the command
// register let requests keep arriving until the queue fills.
module primitive_index_generator_unit #(
  parameter int INDEX_LIMIT = 65534
) (
  input  logic     clk,
  input  logic     rst,
  pig_in_if.sink   req,
  pig_out_if.source res,
  pig_cfg_if.sink  cfg
);

  logic          restart_enable;
  logic          f_valid, f_ready, b_valid, b_ready;
  pig_pkg::cmd_t f_cmd, b_cmd;

  // config register, always writable
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) restart_enable <= 1'b0;
    else if (cfg.valid) restart_enable <= cfg.data;
  end

  pig_front #(.INDEX_LIMIT(INDEX_LIMIT)) u_front (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .req_type(req.req_type), .prim_type(req.prim_type),
    .batch_count(req.batch_count), .restart_enable,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  pig_queue u_queue (
    .clk, .rst,
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_cmd),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_cmd)
  );

  pig_back u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd), .res
  );

  a_status: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind == pig_pkg::KIND_STATUS |-> res.last)
    else $error("status result not last");

endmodule

// File: hw/rtl/pig_front.sv
// ----------------------------------------------------------------------------
// pig_front: request classifier
// Tracks batch position and counts, turns each request into an emit command.
// ----------------------------------------------------------------------------
module pig_front #(
  parameter int INDEX_LIMIT = 65534
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      req_type,
  input  logic [2:0]      prim_type,
  input  logic [15:0]     batch_count,
  input  logic            restart_enable,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output pig_pkg::cmd_t   cmd
);

  logic [31:0] running_index;
  logic [15:0] vertex_position;
  logic [31:0] triangles_made, lines_made, points_made;
  logic [31:0] running_index_next;
  logic [15:0] vertex_position_next;
  logic [31:0] tri_next, line_next, point_next;
  pig_pkg::cmd_t cmd_next;
  logic          emit;

  // fan grouping: (n-2)/3 and (p-2)/3 by small reciprocal multiply
  logic [15:0] nm2, pm2, groups, k, tail;
  logic [1:0]  pr3;
  logic [33:0] prod_n, prod_p;
  localparam logic [17:0] RECIP3 = 18'd43691;  // ceil(2^17/3)

  assign in_ready = cmd_ready;

  always_comb begin
    nm2    = batch_count - 16'd2;
    pm2    = vertex_position - 16'd2;
    prod_n = {18'd0, nm2} * {16'd0, RECIP3};
    prod_p = {18'd0, pm2} * {16'd0, RECIP3};
    groups = prod_n[32:17];
    k      = prod_p[32:17];
    pr3    = 2'(pm2 - 16'(k * 16'd3));
    tail   = 16'(16'd2 + 16'(groups * 16'd3));
  end

  function automatic pig_pkg::slot_t sl(input logic [15:0] o);
    sl.mark   = 1'b0;
    sl.offset = o;
  endfunction

  function automatic pig_pkg::slot_t mk();
    mk.mark   = 1'b1;
    mk.offset = '0;
  endfunction

  always_comb begin
    logic [15:0] p, n, b;
    logic        pr;
    p = vertex_position;
    n = batch_count;
    b = {p[15:2], 2'b00};
    pr = restart_enable;
    running_index_next   = running_index;
    vertex_position_next = vertex_position;
    tri_next   = triangles_made;
    line_next  = lines_made;
    point_next = points_made;
    cmd_next   = '0;
    cmd_next.base = running_index[15:0];
    emit = 1'b0;
    case (req_type)
      pig_pkg::REQ_START: begin
        running_index_next   = '0;
        vertex_position_next = '0;
        tri_next   = '0;
        line_next  = '0;
        point_next = '0;
      end
      pig_pkg::REQ_VERTEX: begin
        if (p < n) begin
          case (prim_type)
            pig_pkg::PRIM_QUADS: begin
              cmd_next.kind = pig_pkg::KIND_TRI;
              if (p[1:0] == 2'd3) begin
                emit = 1'b1;
                tri_next = triangles_made + 32'd2;
                if (pr) begin
                  cmd_next.count = 3'd5;
                  cmd_next.slots[0] = sl(b + 16'd1);
                  cmd_next.slots[1] = sl(b + 16'd2);
                  cmd_next.slots[2] = sl(b);
                  cmd_next.slots[3] = sl(b + 16'd3);
                  cmd_next.slots[4] = mk();
                end else begin
                  cmd_next.count = 3'd6;
                  cmd_next.slots[0] = sl(b);
                  cmd_next.slots[1] = sl(b + 16'd1);
                  cmd_next.slots[2] = sl(b + 16'd2);
                  cmd_next.slots[3] = sl(b);
                  cmd_next.slots[4] = sl(b + 16'd2);
                  cmd_next.slots[5] = sl(b + 16'd3);
                end
              end else if (n[1:0] == 2'd3 && p == n - 16'd1) begin
                emit = 1'b1;
                tri_next = triangles_made + 32'd1;
                cmd_next.count = pr ? 3'd4 : 3'd3;
                cmd_next.slots[0] = sl(n - 16'd3);
                cmd_next.slots[1] = sl(n - 16'd2);
                cmd_next.slots[2] = sl(n - 16'd1);
                cmd_next.slots[3] = mk();
              end
            end
            pig_pkg::PRIM_LIST: begin
              cmd_next.kind = pig_pkg::KIND_TRI;
              // third vertex of a group: (p-2) divisible by three
              if (p >= 16'd2 && pr3 == 2'd0) begin
                emit = 1'b1;
                tri_next = triangles_made + 32'd1;
                cmd_next.count = pr ? 3'd4 : 3'd3;
                cmd_next.slots[0] = sl(p - 16'd2);
                cmd_next.slots[1] = sl(p - 16'd1);
                cmd_next.slots[2] = sl(p);
                cmd_next.slots[3] = mk();
              end
            end
            pig_pkg::PRIM_STRIP: begin
              cmd_next.kind = pig_pkg::KIND_TRI;
              if (pr) begin
                emit = 1'b1;
                cmd_next.count = 3'd1;
                cmd_next.slots[0] = sl(p);
                if (p == n - 16'd1) begin
                  cmd_next.count = 3'd2;
                  cmd_next.slots[1] = mk();
                  if (n >= 16'd2) tri_next = triangles_made + {16'd0, n - 16'd2};
                end
              end else if (p >= 16'd2) begin
                emit = 1'b1;
                tri_next = triangles_made + 32'd1;
                cmd_next.count = 3'd3;
                cmd_next.slots[0] = sl(p - 16'd2);
                cmd_next.slots[1] = sl(p[0] ? p : p - 16'd1);
                cmd_next.slots[2] = sl(p[0] ? p - 16'd1 : p);
              end
            end
            pig_pkg::PRIM_FAN: begin
              cmd_next.kind = pig_pkg::KIND_TRI;
              if (p >= 16'd2) begin
                if (!pr) begin
                  emit = 1'b1;
                  tri_next = triangles_made + 32'd1;
                  cmd_next.count = 3'd3;
                  cmd_next.slots[0] = sl(16'd0);
                  cmd_next.slots[1] = sl(p - 16'd1);
                  cmd_next.slots[2] = sl(p);
                end else if (pr3 == 2'd2 && k < groups) begin
                  emit = 1'b1;
                  tri_next = triangles_made + 32'd3;
                  cmd_next.count = 3'd6;
                  cmd_next.slots[0] = sl(pm2 - 16'd1);
                  cmd_next.slots[1] = sl(pm2);
                  cmd_next.slots[2] = sl(16'd0);
                  cmd_next.slots[3] = sl(pm2 + 16'd1);
                  cmd_next.slots[4] = sl(pm2 + 16'd2);
                  cmd_next.slots[5] = mk();
                end else if (p == n - 16'd1 && p >= tail) begin
                  emit = 1'b1;
                  if (n - tail == 16'd2) begin
                    tri_next = triangles_made + 32'd2;
                    cmd_next.count = 3'd5;
                    cmd_next.slots[0] = sl(tail - 16'd1);
                    cmd_next.slots[1] = sl(tail);
                    cmd_next.slots[2] = sl(16'd0);
                    cmd_next.slots[3] = sl(tail + 16'd1);
                    cmd_next.slots[4] = mk();
                  end else begin
                    tri_next = triangles_made + 32'd1;
                    cmd_next.count = 3'd4;
                    cmd_next.slots[0] = sl(16'd0);
                    cmd_next.slots[1] = sl(p - 16'd1);
                    cmd_next.slots[2] = sl(p);
                    cmd_next.slots[3] = mk();
                  end
                end
              end
            end
            pig_pkg::PRIM_LINES, pig_pkg::PRIM_LINESTRIP: begin
              cmd_next.kind = pig_pkg::KIND_LINE;
              if ((prim_type == pig_pkg::PRIM_LINES) ? p[0] : (p >= 16'd1)) begin
                emit = 1'b1;
                line_next = lines_made + 32'd1;
                cmd_next.count = 3'd2;
                cmd_next.slots[0] = sl(p - 16'd1);
                cmd_next.slots[1] = sl(p);
              end
            end
            pig_pkg::PRIM_POINTS: begin
              emit = 1'b1;
              point_next = points_made + 32'd1;
              cmd_next.kind = pig_pkg::KIND_POINT;
              cmd_next.count = 3'd1;
              cmd_next.slots[0] = sl(p);
            end
            default: ;
          endcase
        end
        if ({1'b0, p} + 17'd1 >= {1'b0, n}) begin
          running_index_next   = running_index + {16'd0, n};
          vertex_position_next = '0;
        end else begin
          vertex_position_next = p + 16'd1;
        end
      end
      pig_pkg::REQ_STATUS: begin
        emit = 1'b1;
        cmd_next.kind  = pig_pkg::KIND_STATUS;
        cmd_next.count = 3'd1;
        cmd_next.tri_count   = triangles_made;
        cmd_next.line_count  = lines_made;
        cmd_next.point_count = points_made;
        cmd_next.remaining   = (running_index < 32'(INDEX_LIMIT)) ?
                               16'(32'(INDEX_LIMIT) - running_index) : 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_index   <= '0;
      vertex_position <= '0;
      triangles_made  <= '0;
      lines_made      <= '0;
      points_made     <= '0;
      cmd_valid       <= 1'b0;
    end else if (in_valid && in_ready) begin
      running_index   <= running_index_next;
      vertex_position <= vertex_position_next;
      triangles_made  <= tri_next;
      lines_made      <= line_next;
      points_made     <= point_next;
      cmd_valid       <= emit;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) cmd <= cmd_next;
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
    else $error("command dropped while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd.count != 3'd0 && cmd.count <= 3'(pig_pkg::MAX_SLOTS))
    else $error("bad slot count");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |-> !in_ready)
    else $error("accepted over a full command register");

endmodule

// File: hw/rtl/pig_queue.sv
// ----------------------------------------------------------------------------
// pig_queue: two-entry command queue
// Decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module pig_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pig_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pig_pkg::cmd_t pop_data
);

  pig_pkg::cmd_t entry [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    fill;
  logic          push, pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");

endmodule

// File: hw/rtl/pig_back.sv
// ----------------------------------------------------------------------------
// pig_back: result emitter
// Walks the slots of one command, one result per cycle unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module pig_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  pig_pkg::cmd_t cmd,
  pig_out_if.source     res
);

  logic [2:0]     slot;
  logic           take;
  logic           last_slot;
  pig_pkg::slot_t cur;

  assign take      = !res.valid || res.ready;
  assign last_slot = (slot == cmd.count - 3'd1);
  assign cmd_ready = take && last_slot;
  assign cur       = cmd.slots[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= '0;
      res.valid <= 1'b0;
    end else if (take) begin
      res.valid <= cmd_valid;
      if (cmd_valid) slot <= last_slot ? 3'd0 : slot + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd_valid) begin
      res.kind        <= cmd.kind;
      res.last        <= last_slot;
      res.index_value <= (cmd.kind == pig_pkg::KIND_STATUS) ? 16'd0 :
                         cur.mark ? pig_pkg::RESTART_MARK : cmd.base + cur.offset;
      res.tri_count   <= cmd.tri_count;
      res.line_count  <= cmd.line_count;
      res.point_count <= cmd.point_count;
      res.remaining   <= cmd.remaining;
    end
  end

  a_slot: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> slot < cmd.count)
    else $error("slot beyond command");
  a_out: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.index_value))
    else $error("result changed while stalled");

endmodule
